### design/rgb_color_effect_filter_macros.svh
// Assertion macros shared by the color effect filter RTL.
`ifndef RGB_COLOR_EFFECT_FILTER_MACROS_SVH
`define RGB_COLOR_EFFECT_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGBCEF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too.
`define RGBCEF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rgbcef_pkg.sv
// Types, constants and arithmetic helpers for the color effect filter.
`default_nettype none

package rgbcef_pkg;

  typedef enum logic [3:0] {
    MODE_NONE    = 4'd0,
    MODE_GRAY    = 4'd1,
    MODE_SEPIA   = 4'd2,
    MODE_COOL    = 4'd3,
    MODE_WARM    = 4'd4,
    MODE_CYBER   = 4'd5,
    MODE_NOIR    = 4'd6,
    MODE_VINTAGE = 4'd7,
    MODE_INVERT  = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    CH_R = 2'd0,
    CH_G = 2'd1,
    CH_B = 2'd2
  } chan_t;

  localparam int NUM_W   = 19;          // weighted sum numerators
  localparam int BLEND_W = 15;          // blend numerators
  localparam int LIN_W   = 28;          // Q16 gain products, signed
  localparam int NOIR_W  = LIN_W + 18;  // Q32 noir product, signed
  localparam int VAL_W   = 11;          // truncated channel values, signed

  // Luma and sepia weights, in thousandths
  localparam logic [9:0] K_YR  = 10'd299;
  localparam logic [9:0] K_YG  = 10'd587;
  localparam logic [9:0] K_YB  = 10'd114;
  localparam logic [9:0] K_SRR = 10'd393;
  localparam logic [9:0] K_SRG = 10'd769;
  localparam logic [9:0] K_SRB = 10'd189;
  localparam logic [9:0] K_SGR = 10'd349;
  localparam logic [9:0] K_SGG = 10'd686;
  localparam logic [9:0] K_SGB = 10'd168;
  localparam logic [9:0] K_SBR = 10'd272;
  localparam logic [9:0] K_SBG = 10'd534;
  localparam logic [9:0] K_SBB = 10'd131;

  // Blend weights, in hundredths
  localparam logic [6:0] W_HI = 7'd65;
  localparam logic [6:0] W_LO = 7'd35;

  // Exact reciprocals: n/1000 for n < 2^19, n/100 for n < 2^15
  localparam logic [19:0] DIV1000_M  = 20'd536871;
  localparam int          DIV1000_SH = 29;
  localparam logic [15:0] DIV100_M   = 16'd41944;
  localparam int          DIV100_SH  = 22;

  // Q16 gains
  localparam logic [16:0] G_1_08 = 17'd70779;
  localparam logic [16:0] G_0_90 = 17'd58982;
  localparam logic [16:0] G_1_02 = 17'd66847;
  localparam logic [16:0] G_1_18 = 17'd77332;
  localparam logic [16:0] G_1_15 = 17'd75366;
  localparam logic [16:0] G_1_04 = 17'd68157;
  localparam logic [16:0] G_0_88 = 17'd57672;
  localparam logic [16:0] G_1_30 = 17'd85197;
  localparam logic [16:0] G_1_20 = 17'd78643;
  localparam logic [16:0] G_1_40 = 17'd91750;
  localparam logic [16:0] G_1_70 = 17'd111411;
  localparam logic [16:0] G_0_92 = 17'd60293;

  localparam logic [7:0] MID = 8'd128;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

  typedef struct packed {
    pix_t       pix;
    logic [7:0] y;
    logic [8:0] sr;
    logic [8:0] sg;
    logic [8:0] sb;
  } luma_t;

  typedef struct packed {
    pix_t                    pix;
    logic signed [VAL_W-1:0] vr;
    logic signed [VAL_W-1:0] vg;
    logic signed [VAL_W-1:0] vb;
  } tone_t;

  typedef struct packed {
    logic signed [9:0] x;
    logic [16:0]       gq;
    logic [7:0]        off;
  } gsel_t;

  function automatic logic [NUM_W-1:0] wsum(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [9:0] kr,
                                            input logic [9:0] kg, input logic [9:0] kb);
    return NUM_W'(r) * NUM_W'(kr) + NUM_W'(g) * NUM_W'(kg) + NUM_W'(b) * NUM_W'(kb);
  endfunction

  function automatic logic [8:0] div1000(input logic [NUM_W-1:0] n);
    logic [NUM_W+19:0] p;
    p = (NUM_W+20)'(n) * (NUM_W+20)'(DIV1000_M);
    return p[DIV1000_SH+8:DIV1000_SH];
  endfunction

  function automatic logic [8:0] div100(input logic [BLEND_W-1:0] n);
    logic [BLEND_W+15:0] p;
    p = (BLEND_W+16)'(n) * (BLEND_W+16)'(DIV100_M);
    return p[DIV100_SH+8:DIV100_SH];
  endfunction

  function automatic logic [BLEND_W-1:0] blend_num(input logic [3:0] mode,
                                                   input logic [7:0] c, input logic [8:0] s);
    logic [BLEND_W-1:0] wc;
    logic [BLEND_W-1:0] ws;
    if (mode == MODE_VINTAGE) begin
      wc = BLEND_W'(W_HI);
      ws = BLEND_W'(W_LO);
    end else begin
      wc = BLEND_W'(W_LO);
      ws = BLEND_W'(W_HI);
    end
    return BLEND_W'(c) * wc + BLEND_W'(s) * ws;
  endfunction

  // Pick the operand, gain and offset of the linear effects for one channel.
  function automatic gsel_t gain_sel(input logic [3:0] mode, input chan_t ch,
                                     input logic [7:0] c, input logic [7:0] y);
    gsel_t             s;
    logic signed [9:0] cx;
    logic signed [9:0] cc;
    logic signed [9:0] yc;
    cx = signed'({2'b00, c});
    cc = cx - 10'sd128;
    yc = signed'({2'b00, y}) - 10'sd128;
    s  = '0;
    case (mode)
      MODE_GRAY: s = '{x: yc, gq: G_1_08, off: MID};
      MODE_NOIR: s = '{x: yc, gq: G_1_70, off: MID};
      MODE_COOL: begin
        case (ch)
          CH_R:    s = '{x: cx, gq: G_0_90, off: 8'd5};
          CH_G:    s = '{x: cx, gq: G_1_02, off: 8'd0};
          default: s = '{x: cx, gq: G_1_18, off: 8'd15};
        endcase
      end
      MODE_WARM: begin
        case (ch)
          CH_R:    s = '{x: cx, gq: G_1_15, off: 8'd10};
          CH_G:    s = '{x: cx, gq: G_1_04, off: 8'd0};
          default: s = '{x: cx, gq: G_0_88, off: 8'd0};
        endcase
      end
      MODE_CYBER: begin
        case (ch)
          CH_R:    s = '{x: cc, gq: G_1_30, off: 8'd158};
          CH_G:    s = '{x: cc, gq: G_1_20, off: 8'd113};
          default: s = '{x: cc, gq: G_1_40, off: 8'd168};
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic signed [LIN_W-1:0] lin_of(input gsel_t s);
    return LIN_W'(s.x) * LIN_W'(signed'({1'b0, s.gq}))
         + signed'(LIN_W'({s.off, 16'h0000}));
  endfunction

  // Drop 16 fraction bits, rounding toward zero.
  function automatic logic signed [VAL_W-1:0] trunc_lin(input logic signed [LIN_W-1:0] v);
    logic [LIN_W-1:0]  m;
    logic [LIN_W-17:0] q;
    m = v[LIN_W-1] ? -v : v;
    q = m[LIN_W-1:16];
    return v[LIN_W-1] ? -signed'(VAL_W'(q)) : signed'(VAL_W'(q));
  endfunction

  // Drop 32 fraction bits, rounding toward zero.
  function automatic logic signed [VAL_W-1:0] trunc_noir(input logic signed [NOIR_W-1:0] v);
    logic [NOIR_W-1:0]  m;
    logic [NOIR_W-33:0] q;
    m = v[NOIR_W-1] ? -v : v;
    q = m[NOIR_W-1:32];
    return v[NOIR_W-1] ? -signed'(VAL_W'(q)) : signed'(VAL_W'(q));
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [VAL_W-1:0] v);
    logic [7:0] c;
    if (v[VAL_W-1]) begin
      c = 8'h00;
    end else if (|v[VAL_W-2:8]) begin
      c = 8'hFF;
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/rgbcef_luma.sv
// Two pipeline stages: luma and sepia weighted sums, then divide by 1000.
`default_nettype none

module rgbcef_luma import rgbcef_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        up_valid,
  output logic       up_ready,
  input  wire pix_t  up,
  output logic       dn_valid,
  input  wire        dn_ready,
  output luma_t      dn
);

  logic             v1;
  logic             v2;
  logic             en1;
  logic             en2;
  pix_t             p1;
  logic [NUM_W-1:0] ny;
  logic [NUM_W-1:0] nr;
  logic [NUM_W-1:0] ng;
  logic [NUM_W-1:0] nb;
  luma_t            q2;

  // A stage advances when it is empty or the next one takes its request.
  assign en2      = !v2 || dn_ready;
  assign en1      = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v2;
  assign dn       = q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= up_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      p1 <= up;
      ny <= wsum(up.r, up.g, up.b, K_YR, K_YG, K_YB);
      nr <= wsum(up.r, up.g, up.b, K_SRR, K_SRG, K_SRB);
      ng <= wsum(up.r, up.g, up.b, K_SGR, K_SGG, K_SGB);
      nb <= wsum(up.r, up.g, up.b, K_SBR, K_SBG, K_SBB);
    end
    if (en2 && v1) begin
      q2.pix <= p1;
      q2.y   <= 8'(div1000(ny));
      q2.sr  <= div1000(nr);
      q2.sg  <= div1000(ng);
      q2.sb  <= div1000(nb);
    end
  end

endmodule

`default_nettype wire

### design/rgbcef_tone.sv
// Two pipeline stages: gain products and blend sums, then scaling and truncation.
`default_nettype none

module rgbcef_tone import rgbcef_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        up_valid,
  output logic       up_ready,
  input  wire luma_t up,
  output logic       dn_valid,
  input  wire        dn_ready,
  output tone_t      dn
);

  logic                     v1;
  logic                     v2;
  logic                     en1;
  logic                     en2;
  pix_t                     p1;
  logic [BLEND_W-1:0]       bn_r;
  logic [BLEND_W-1:0]       bn_g;
  logic [BLEND_W-1:0]       bn_b;
  logic signed [LIN_W-1:0]  lin_r;
  logic signed [LIN_W-1:0]  lin_g;
  logic signed [LIN_W-1:0]  lin_b;
  gsel_t                    gs_r;
  gsel_t                    gs_g;
  gsel_t                    gs_b;
  logic signed [NOIR_W-1:0] noir_p;
  logic signed [VAL_W-1:0]  noir_v;
  logic signed [VAL_W-1:0]  val_r;
  logic signed [VAL_W-1:0]  val_g;
  logic signed [VAL_W-1:0]  val_b;
  tone_t                    q2;

  assign en2      = !v2 || dn_ready;
  assign en1      = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v2;
  assign dn       = q2;

  assign gs_r = gain_sel(up.pix.mode, CH_R, up.pix.r, up.y);
  assign gs_g = gain_sel(up.pix.mode, CH_G, up.pix.g, up.y);
  assign gs_b = gain_sel(up.pix.mode, CH_B, up.pix.b, up.y);

  // Noir is the same on every channel: scale the red inner value by 0.9.
  assign noir_p = NOIR_W'(lin_r) * NOIR_W'(signed'({1'b0, G_0_90}));
  assign noir_v = trunc_noir(noir_p);

  always_comb begin
    case (p1.mode) inside
      MODE_SEPIA, MODE_VINTAGE: begin
        val_r = signed'(VAL_W'(div100(bn_r)));
        val_g = signed'(VAL_W'(div100(bn_g)));
        val_b = signed'(VAL_W'(div100(bn_b)));
      end
      MODE_NOIR: begin
        val_r = noir_v;
        val_g = noir_v;
        val_b = noir_v;
      end
      MODE_GRAY, MODE_COOL, MODE_WARM, MODE_CYBER: begin
        val_r = trunc_lin(lin_r);
        val_g = trunc_lin(lin_g);
        val_b = trunc_lin(lin_b);
      end
      default: begin
        val_r = '0;
        val_g = '0;
        val_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= up_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      p1    <= up.pix;
      bn_r  <= blend_num(up.pix.mode, up.pix.r, up.sr);
      bn_g  <= blend_num(up.pix.mode, up.pix.g, up.sg);
      bn_b  <= blend_num(up.pix.mode, up.pix.b, up.sb);
      lin_r <= lin_of(gs_r);
      lin_g <= lin_of(gs_g);
      lin_b <= lin_of(gs_b);
    end
    if (en2 && v1) begin
      q2.pix <= p1;
      q2.vr  <= val_r;
      q2.vg  <= val_g;
      q2.vb  <= val_b;
    end
  end

endmodule

`default_nettype wire

### design/rgbcef_final.sv
// Output stage: vintage blue gain, clamp, invert and pass-through select.
`default_nettype none

module rgbcef_final import rgbcef_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        up_valid,
  output logic       up_ready,
  input  wire tone_t up,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out
);

  logic                    en;
  logic [25:0]             vint_p;
  logic signed [VAL_W-1:0] vint_b;
  logic [7:0]              red_next;
  logic [7:0]              green_next;
  logic [7:0]              blue_next;

  assign en       = !out_valid || out_ready;
  assign up_ready = en;

  // Blend result is never negative, so the low ten bits carry it.
  assign vint_p = 26'(up.vb[9:0]) * 26'(G_0_92);
  assign vint_b = signed'({1'b0, vint_p[25:16]});

  always_comb begin
    case (up.pix.mode) inside
      MODE_INVERT: begin
        red_next   = ~up.pix.r;
        green_next = ~up.pix.g;
        blue_next  = ~up.pix.b;
      end
      MODE_GRAY, MODE_SEPIA, MODE_COOL, MODE_WARM, MODE_CYBER, MODE_NOIR: begin
        red_next   = clamp8(up.vr);
        green_next = clamp8(up.vg);
        blue_next  = clamp8(up.vb);
      end
      MODE_VINTAGE: begin
        red_next   = clamp8(up.vr);
        green_next = clamp8(up.vg);
        blue_next  = clamp8(vint_b);
      end
      default: begin
        red_next   = up.pix.r;
        green_next = up.pix.g;
        blue_next  = up.pix.b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      red_out   <= red_next;
      green_out <= green_next;
      blue_out  <= blue_next;
      alpha_out <= up.pix.a;
    end
  end

endmodule

`default_nettype wire

### design/rgb_color_effect_filter.sv
// Top level of the per-pixel RGBA color effect filter.
`default_nettype none

// Recolors one RGBA8888 pixel per clock with one of nine effects chosen by
// effect_mode (none, gray, sepia, cool, warm, cyber, noir, vintage, invert;
// codes 9 to 15 pass the pixel through), alpha copied unchanged. The
// pipeline has five register stages: weighted sums, divide by 1000, gain
// products and blend sums, divide by 100 with truncation, and the output
// register with clamping. A new pixel can be taken every cycle unless
// out_ready stalls the pipeline; each stage holds one multiplier column,
// which sets the clock rate. Backpressure runs from out_ready to in_ready
// through the stage enables in the same cycle, and empty stages fill while
// the output waits. Write effect_mode only while no pixel is in flight;
// each pixel carries the mode it was accepted with.

`include "rgb_color_effect_filter_macros.svh"

module rgb_color_effect_filter import rgbcef_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_wr_en,
  input  wire  [3:0] cfg_wr_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] red_in,
  input  wire  [7:0] green_in,
  input  wire  [7:0] blue_in,
  input  wire  [7:0] alpha_in,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out
);

  logic [3:0] effect_mode;
  pix_t       pix_in;
  logic       luma_valid;
  logic       luma_ready;
  luma_t      luma_data;
  logic       tone_valid;
  logic       tone_ready;
  tone_t      tone_data;
  logic       tone_blend;
  logic       tone_mono;
  logic       tone_neg;
  logic       tone_same;
  logic       pipe_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= MODE_NONE;
    end else if (cfg_wr_en) begin
      effect_mode <= cfg_wr_data;
    end
  end

  assign pix_in = '{mode: effect_mode, r: red_in, g: green_in, b: blue_in, a: alpha_in};

  rgbcef_luma u_luma (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up       (pix_in),
    .dn_valid (luma_valid),
    .dn_ready (luma_ready),
    .dn       (luma_data)
  );

  rgbcef_tone u_tone (
    .clk      (clk),
    .rst      (rst),
    .up_valid (luma_valid),
    .up_ready (luma_ready),
    .up       (luma_data),
    .dn_valid (tone_valid),
    .dn_ready (tone_ready),
    .dn       (tone_data)
  );

  rgbcef_final u_final (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (tone_valid),
    .up_ready  (tone_ready),
    .up        (tone_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out)
  );

  assign tone_blend = tone_data.pix.mode == MODE_SEPIA || tone_data.pix.mode == MODE_VINTAGE;
  assign tone_mono  = tone_data.pix.mode == MODE_GRAY || tone_data.pix.mode == MODE_NOIR;
  assign tone_neg   = tone_data.vr[VAL_W-1] || tone_data.vg[VAL_W-1] || tone_data.vb[VAL_W-1];
  assign tone_same  = tone_data.vr == tone_data.vg && tone_data.vg == tone_data.vb;
  assign pipe_busy  = out_valid || luma_valid || tone_valid;

  `RGBCEF_ASSERT_IMP(a_sepia_red_range, luma_valid, luma_data.sr <= 9'd344, "sepia red sum out of range")
  `RGBCEF_ASSERT_IMP(a_blend_nonneg, tone_valid && tone_blend, !tone_neg, "negative blend result")
  `RGBCEF_ASSERT_IMP(a_mono_equal, tone_valid && tone_mono, tone_same, "monochrome channels differ")
  `RGBCEF_ASSERT_NXT(a_reset_empty, rst, !pipe_busy, "pipeline not empty after reset")

endmodule

`default_nettype wire

### test/rgb_color_effect_filter_tb.sv
// Self-checking testbench for the RGBA color effect filter.
`timescale 1ns / 100ps

module rgb_color_effect_filter_tb import rgbcef_pkg::*;;

  localparam logic [3:0] MODE_SPARE_TOP = 4'hF;
  localparam int         SETTLE_CYCLES  = 10;
  localparam int         CYCLE_LIMIT    = 200000;
  localparam int         RAND_PHASES    = 26;
  localparam int         PHASE_PIXELS   = 50;
  localparam int         QUIET_PHASES   = 3;

  // Q16 gains, rounded to nearest
  localparam longint Q16_1_08 = 70779;
  localparam longint Q16_0_90 = 58982;
  localparam longint Q16_1_02 = 66847;
  localparam longint Q16_1_18 = 77332;
  localparam longint Q16_1_15 = 75366;
  localparam longint Q16_1_04 = 68157;
  localparam longint Q16_0_88 = 57672;
  localparam longint Q16_1_30 = 85197;
  localparam longint Q16_1_20 = 78643;
  localparam longint Q16_1_40 = 91750;
  localparam longint Q16_1_70 = 111411;
  localparam longint Q16_0_92 = 60293;
  localparam longint Q16_UNIT = 65536;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  logic       clk;
  logic       rst         = 1'b1;
  logic       cfg_wr_en   = 1'b0;
  logic [3:0] cfg_wr_data = 4'h0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] red_in      = 8'h00;
  logic [7:0] green_in    = 8'h00;
  logic [7:0] blue_in     = 8'h00;
  logic [7:0] alpha_in    = 8'h00;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  rgba_t      pixel_feed[$];
  rgba_t      recolored_q[$];
  logic [3:0] active_mode   = 4'h0;
  bit         quiet         = 1'b0;
  int         errors        = 0;
  int         pixels_queued = 0;
  int         pixels_in     = 0;
  int         pixels_out    = 0;
  int         mode_writes   = 0;
  int         cycle_count   = 0;
  int         gap_left      = 0;
  int         stall_left    = 0;

  rgb_color_effect_filter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .alpha_in   (alpha_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .alpha_out  (alpha_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] sat8(input longint v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  // Shift right, rounding toward zero.
  function automatic longint shr_trunc(input longint v, input int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic logic [7:0] scale_q16(input longint x, input longint gq,
                                           input longint off);
    return sat8(shr_trunc(x * gq + off * Q16_UNIT, 16));
  endfunction

  function automatic rgba_t recolor(input logic [3:0] mode, input rgba_t px);
    rgba_t  o;
    longint r, g, b, luma, sep_r, sep_g, sep_b, noir_q, vin_b;
    r     = px.r;
    g     = px.g;
    b     = px.b;
    luma  = (r * 299 + g * 587 + b * 114) / 1000;
    sep_r = (r * 393 + g * 769 + b * 189) / 1000;
    sep_g = (r * 349 + g * 686 + b * 168) / 1000;
    sep_b = (r * 272 + g * 534 + b * 131) / 1000;
    o     = px;
    case (mode)
      MODE_GRAY: begin
        o.r = scale_q16(luma - 128, Q16_1_08, 128);
        o.g = o.r;
        o.b = o.r;
      end
      MODE_SEPIA: begin
        o.r = sat8((r * 35 + sep_r * 65) / 100);
        o.g = sat8((g * 35 + sep_g * 65) / 100);
        o.b = sat8((b * 35 + sep_b * 65) / 100);
      end
      MODE_COOL: begin
        o.r = scale_q16(r, Q16_0_90, 5);
        o.g = scale_q16(g, Q16_1_02, 0);
        o.b = scale_q16(b, Q16_1_18, 15);
      end
      MODE_WARM: begin
        o.r = scale_q16(r, Q16_1_15, 10);
        o.g = scale_q16(g, Q16_1_04, 0);
        o.b = scale_q16(b, Q16_0_88, 0);
      end
      MODE_CYBER: begin
        o.r = scale_q16(r - 128, Q16_1_30, 158);
        o.g = scale_q16(g - 128, Q16_1_20, 113);
        o.b = scale_q16(b - 128, Q16_1_40, 168);
      end
      MODE_NOIR: begin
        // Q16 contrast value times Q16 gain, truncated once from Q32
        noir_q = (luma - 128) * Q16_1_70 + 128 * Q16_UNIT;
        o.r    = sat8(shr_trunc(noir_q * Q16_0_90, 32));
        o.g    = o.r;
        o.b    = o.r;
      end
      MODE_VINTAGE: begin
        vin_b = (b * 65 + sep_b * 35) / 100;
        o.r   = sat8((r * 65 + sep_r * 35) / 100);
        o.g   = sat8((g * 65 + sep_g * 35) / 100);
        o.b   = scale_q16(vin_b, Q16_0_92, 0);
      end
      MODE_INVERT: begin
        o.r = 8'hFF - px.r;
        o.g = 8'hFF - px.g;
        o.b = 8'hFF - px.b;
      end
      default: o = px;
    endcase
    return o;
  endfunction

  function automatic rgba_t rand_pixel();
    rgba_t p;
    int    kind, base;
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    p.a  = 8'($urandom_range(0, 255));
    if (kind == 0) begin
      p.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (kind == 1) begin
      // near-neutral pixel, sweeps the luma contrast curves
      p.r = sat8(base + int'($urandom_range(0, 8)) - 4);
      p.g = sat8(base + int'($urandom_range(0, 8)) - 4);
      p.b = sat8(base + int'($urandom_range(0, 8)) - 4);
    end else begin
      p.r = 8'($urandom_range(0, 255));
      p.g = 8'($urandom_range(0, 255));
      p.b = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Wait until every queued pixel has come back, then let the pipeline settle.
  task automatic drain();
    while (pixel_feed.size() != 0 || pixels_out < pixels_queued)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [3:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_mode = m;
    mode_writes++;
  endtask

  task automatic push_rgba(input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a);
    rgba_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    p.a = a;
    pixel_feed.push_back(p);
    pixels_queued++;
  endtask

  // Request driver
  always @(posedge clk) begin : drive_requests
    rgba_t nxt;
    rgba_t sent;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        sent.r = red_in;
        sent.g = green_in;
        sent.b = blue_in;
        sent.a = alpha_in;
        recolored_q.push_back(recolor(active_mode, sent));
        pixels_in++;
      end
      if (in_valid && !in_ready) begin
        // hold the request until taken
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pixel_feed.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(0, 4);
      end else if (pixel_feed.size() != 0) begin
        nxt = pixel_feed.pop_front();
        in_valid <= 1'b1;
        red_in   <= nxt.r;
        green_in <= nxt.g;
        blue_in  <= nxt.b;
        alpha_in <= nxt.a;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random output stalls
  always @(posedge clk) begin : watch_results
    rgba_t want;
    if (!rst && out_valid && out_ready) begin
      if (recolored_q.size() == 0) begin
        flag_mismatch("unexpected pixel, red", red_out, 0);
      end else begin
        want = recolored_q.pop_front();
        if (red_out !== want.r)   flag_mismatch("red_out", red_out, want.r);
        if (green_out !== want.g) flag_mismatch("green_out", green_out, want.g);
        if (blue_out !== want.b)  flag_mismatch("blue_out", blue_out, want.b);
        if (alpha_out !== want.a) flag_mismatch("alpha_out", alpha_out, want.a);
      end
      pixels_out++;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected",
               cycle_count, recolored_q.size());
      $display("rgb_color_effect_filter_tb NOT OK");
      $finish;
    end
  end

  initial begin : run_sequence
    logic [3:0] directed_modes[10];
    logic [3:0] m;
    directed_modes = '{MODE_NONE, MODE_GRAY, MODE_SEPIA, MODE_COOL, MODE_WARM,
                       MODE_CYBER, MODE_NOIR, MODE_VINTAGE, MODE_INVERT, MODE_SPARE_TOP};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Black drives gray and cyber below zero, white saturates the gains.
    foreach (directed_modes[i]) begin
      write_mode(directed_modes[i]);
      push_rgba(8'h00, 8'h00, 8'h00, 8'h00);
      push_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drain();
    end

    // Sweep every mode code, then random codes; drop idling in the last phases.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 16)
        m = 4'(ph);
      else if ($urandom_range(0, 3) == 0)
        m = 4'($urandom_range(MODE_INVERT + 1, MODE_SPARE_TOP));
      else
        m = 4'($urandom_range(MODE_NONE, MODE_INVERT));
      if (ph >= RAND_PHASES - QUIET_PHASES)
        quiet = 1'b1;
      write_mode(m);
      repeat (PHASE_PIXELS) begin
        pixel_feed.push_back(rand_pixel());
        pixels_queued++;
      end
      drain();
    end

    $display("pixels sent %0d, pixels checked %0d, mode writes %0d",
             pixels_in, pixels_out, mode_writes);
    $display("all 16 mode codes exercised with random stalls on both sides");
    if (errors == 0 && recolored_q.size() == 0) begin
      $display("rgb_color_effect_filter_tb OK");
    end else begin
      $display("rgb_color_effect_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/rgbcef_pkg.sv
design/rgbcef_luma.sv
design/rgbcef_tone.sv
design/rgbcef_final.sv
design/rgb_color_effect_filter.sv
test/rgb_color_effect_filter_tb.sv
